[hw/rtl/hjo_pkg.sv]
// Shared constants for the Halton jitter offset pipeline.
// No dependencies; imported by the digit cell, divide cell and top level.
package hjo_pkg;

	localparam int TERNARY_DIGITS = 21;
	localparam int DIGIT_VALUE_BITS = 34;
	localparam logic [DIGIT_VALUE_BITS-1:0] TERNARY_SCALE = 34'd10460353203;

endpackage

[hw/rtl/hjo_digit_cell.sv]
// One ternary digit step: peels the low base-3 digit off the index and
// appends it to the reversed-digit value. Depends on hjo_pkg.
module hjo_digit_cell #(
	parameter int INDEX_BITS = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  up_valid,
	output logic                                  up_ready,
	input  logic [INDEX_BITS-1:0]                 n_in,
	input  logic [hjo_pkg::DIGIT_VALUE_BITS-1:0]  d_in,
	input  logic [FRACTION_BITS-1:0]              x_in,
	output logic                                  dn_valid,
	input  logic                                  dn_ready,
	output logic [INDEX_BITS-1:0]                 n_out,
	output logic [hjo_pkg::DIGIT_VALUE_BITS-1:0]  d_out,
	output logic [FRACTION_BITS-1:0]              x_out
);
	import hjo_pkg::*;

	localparam int K = INDEX_BITS + 1;
	localparam int PW = 2 * INDEX_BITS + 1;
	localparam logic [K-1:0] RECIP = K'(((64'd1 << K) + 64'd2) / 64'd3);

	logic                        v_q;
	logic [INDEX_BITS-1:0]       n_q;
	logic [DIGIT_VALUE_BITS-1:0] d_q;
	logic [FRACTION_BITS-1:0]    x_q;
	logic [PW-1:0]               prod;
	logic [INDEX_BITS-1:0]       quot;
	logic [1:0]                  rem;
	logic [DIGIT_VALUE_BITS-1:0] d_next;

	// floor(n/3) by reciprocal multiply, exact for all INDEX_BITS-bit n
	assign prod = PW'(n_in) * PW'(RECIP);
	assign quot = prod[PW-1:K];
	assign rem = n_in[1:0] - (quot[1:0] + {quot[0], 1'b0});
	assign d_next = {d_in[DIGIT_VALUE_BITS-2:0], 1'b0} + d_in
		+ {{(DIGIT_VALUE_BITS-2){1'b0}}, rem};

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			n_q <= quot;
			d_q <= d_next;
			x_q <= x_in;
		end
	end

	assign dn_valid = v_q;
	assign n_out = n_q;
	assign d_out = d_q;
	assign x_out = x_q;

endmodule

[hw/rtl/hjo_div_cell.sv]
// One restoring-division step of the reversed-digit value by 3^21,
// producing one fraction bit per cell. Depends on hjo_pkg.
module hjo_div_cell #(
	parameter int FRACTION_BITS = 24
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  up_valid,
	output logic                                  up_ready,
	input  logic [hjo_pkg::DIGIT_VALUE_BITS-1:0]  r_in,
	input  logic [FRACTION_BITS-1:0]              q_in,
	input  logic [FRACTION_BITS-1:0]              x_in,
	output logic                                  dn_valid,
	input  logic                                  dn_ready,
	output logic [hjo_pkg::DIGIT_VALUE_BITS-1:0]  r_out,
	output logic [FRACTION_BITS-1:0]              q_out,
	output logic [FRACTION_BITS-1:0]              x_out
);
	import hjo_pkg::*;

	logic                        v_q;
	logic [DIGIT_VALUE_BITS-1:0] r_q;
	logic [FRACTION_BITS-1:0]    q_q;
	logic [FRACTION_BITS-1:0]    x_q;
	logic [DIGIT_VALUE_BITS:0]   r2;
	logic [DIGIT_VALUE_BITS:0]   diff;
	logic                        take;

	assign r2 = {r_in, 1'b0};
	assign diff = r2 - {1'b0, TERNARY_SCALE};
	assign take = (r2 >= {1'b0, TERNARY_SCALE});

	assign up_ready = !v_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_ready) begin
			v_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			r_q <= take ? diff[DIGIT_VALUE_BITS-1:0] : r2[DIGIT_VALUE_BITS-1:0];
			q_q <= {q_in[FRACTION_BITS-2:0], take};
			x_q <= x_in;
		end
	end

	assign dn_valid = v_q;
	assign r_out = r_q;
	assign q_out = q_q;
	assign x_out = x_q;

endmodule

[hw/rtl/halton_jitter_offset.sv]
// Halton jitter offset, bases 2 and 3: top level. Uses hjo_pkg, hjo_digit_cell, hjo_div_cell.
// Throughput: one transfer per cycle while out_stall is low; every cell holds one item, bubbles collapse under stall.
// Base-3 digits take 21 cells, each fraction bit of the divide by 3^21 takes one cell.
// Reset: asynchronous, active low, clears all cell valid bits; payload registers are not reset.
module halton_jitter_offset #(
	parameter int INDEX_BITS = 32,
	parameter int FRACTION_BITS = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [31:0]                     phase_index,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic signed [FRACTION_BITS-1:0] offset_x,
	output logic signed [FRACTION_BITS-1:0] offset_y
);
	import hjo_pkg::*;

	localparam int NT = TERNARY_DIGITS;
	localparam int NS = TERNARY_DIGITS + FRACTION_BITS;

	logic                        vld   [0:NS];
	logic                        rdy   [0:NS];
	logic [FRACTION_BITS-1:0]    x_w   [0:NS];
	logic [INDEX_BITS-1:0]       n_w   [0:NT];
	logic [DIGIT_VALUE_BITS-1:0] d_w   [0:NS];
	logic [FRACTION_BITS-1:0]    q_w   [NT:NS];
	logic [31:0]                 idx_wide;
	logic [FRACTION_BITS-1:0]    x_in;

	assign idx_wide = 32'(phase_index[INDEX_BITS-1:0]);

	// base-2 radical inverse is a bit reversal; minus one half flips the MSB
	always_comb begin
		x_in = '0;
		for (int k = 0; k < FRACTION_BITS; k++) begin
			x_in[FRACTION_BITS-1-k] = idx_wide[k];
		end
		x_in[FRACTION_BITS-1] = ~idx_wide[0];
	end

	assign vld[0] = in_valid;
	assign in_stall = !rdy[0];
	assign n_w[0] = phase_index[INDEX_BITS-1:0];
	assign d_w[0] = '0;
	assign x_w[0] = x_in;
	assign q_w[NT] = '0;

	for (genvar i = 0; i < NT; i++) begin : g_digit
		hjo_digit_cell #(
			.INDEX_BITS(INDEX_BITS),
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(vld[i]),
			.up_ready(rdy[i]),
			.n_in(n_w[i]),
			.d_in(d_w[i]),
			.x_in(x_w[i]),
			.dn_valid(vld[i+1]),
			.dn_ready(rdy[i+1]),
			.n_out(n_w[i+1]),
			.d_out(d_w[i+1]),
			.x_out(x_w[i+1])
		);
	end

	for (genvar j = NT; j < NS; j++) begin : g_div
		hjo_div_cell #(
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.up_valid(vld[j]),
			.up_ready(rdy[j]),
			.r_in(d_w[j]),
			.q_in(q_w[j]),
			.x_in(x_w[j]),
			.dn_valid(vld[j+1]),
			.dn_ready(rdy[j+1]),
			.r_out(d_w[j+1]),
			.q_out(q_w[j+1]),
			.x_out(x_w[j+1])
		);
	end

	assign rdy[NS] = !out_stall;
	assign out_valid = vld[NS];
	assign offset_x = x_w[NS];
	assign offset_y = {~q_w[NS][FRACTION_BITS-1], q_w[NS][FRACTION_BITS-2:0]};

endmodule

[hw/rtl/hjo_checker.sv]
// Port-level checks for halton_jitter_offset, attached by the bind below.
// Depends only on the top level's ports.
module hjo_checker #(
	parameter int FRACTION_BITS = 24
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic [31:0]              phase_index,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [FRACTION_BITS-1:0] offset_x,
	input logic [FRACTION_BITS-1:0] offset_y
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(offset_x) && $stable(offset_y))
		else $error("output payload changed while stalled");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled while output not blocked");

	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(phase_index))
		else $error("phase_index unknown while in_valid is high");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("out_valid high during reset");

endmodule

bind halton_jitter_offset hjo_checker #(
	.FRACTION_BITS(FRACTION_BITS)
) u_hjo_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.phase_index(phase_index),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.offset_x(offset_x),
	.offset_y(offset_y)
);

[test/tb.sv]
`timescale 1ns / 1ps
// Testbench for halton_jitter_offset: drives phase indices, predicts the base-2/base-3
// jitter offset pair and checks every output transfer in order. Depends on hjo_pkg.
module tb;
	import hjo_pkg::*;

	localparam int FRAC = 24;
	localparam logic [FRAC-1:0] HALF = FRAC'(1) << (FRAC - 1);

	typedef struct packed {
		logic [31:0]            idx;
		logic signed [FRAC-1:0] x;
		logic signed [FRAC-1:0] y;
	} offset_pair_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [31:0]            phase_index;
	logic                   out_valid;
	logic                   out_stall;
	logic signed [FRAC-1:0] offset_x;
	logic signed [FRAC-1:0] offset_y;

	offset_pair_t pending_offsets[$];
	int           errors = 0;
	int           sent = 0;
	int           checked = 0;
	int           input_stalls = 0;
	int           long_holds = 0;
	bit           tx_idle_en = 1'b1;
	bit           rx_idle_en = 1'b1;
	bit           hold_request = 1'b0;
	int           hold_len = 0;

	halton_jitter_offset dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.phase_index(phase_index),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.offset_x   (offset_x),
		.offset_y   (offset_y)
	);

	always #6 clk = ~clk;

	function automatic offset_pair_t predict_offsets(input logic [31:0] idx);
		offset_pair_t    p;
		logic [31:0]     rev;
		longint unsigned n;
		longint unsigned digits;
		longint unsigned rem;
		logic [FRAC-1:0] qy;
		p.idx = idx;
		for (int i = 0; i < 32; i++)
			rev[31-i] = idx[i];
		p.x = rev[31:32-FRAC] - HALF;
		n = 64'(idx);
		digits = 0;
		for (int i = 0; i < TERNARY_DIGITS; i++) begin
			digits = digits * 3 + n % 3;
			n = n / 3;
		end
		rem = digits;
		qy = '0;
		for (int i = 0; i < FRAC; i++) begin
			rem = rem << 1;
			qy = {qy[FRAC-2:0], 1'b0};
			if (rem >= longint'(TERNARY_SCALE)) begin
				rem = rem - longint'(TERNARY_SCALE);
				qy[0] = 1'b1;
			end
		end
		p.y = qy - HALF;
		return p;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] idx,
			input logic [FRAC-1:0] got, input logic [FRAC-1:0] want);
		errors++;
		if (errors <= 40)
			$display("MISMATCH %s idx=%08h got=%06h exp=%06h at %0t", what, idx, got, want,
				$realtime);
	endtask

	// sender: optional idle burst, then hold the transfer until accepted
	task automatic send_phase_index(input logic [31:0] idx);
		if (tx_idle_en && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_valid <= 1'b1;
		phase_index <= idx;
		do begin
			@(posedge clk);
			if (in_stall)
				input_stalls++;
		end while (in_stall);
		pending_offsets.push_back(predict_offsets(idx));
		sent++;
	endtask

	task automatic wait_for_offsets();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_offsets.size() != 0);
	endtask

	// receiver stall generator; a long hold is counted here, independent of the sender
	initial begin
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_stall <= 1'b1;
				repeat (hold_len) @(posedge clk);
				out_stall <= 1'b0;
				hold_request = 1'b0;
				long_holds++;
			end else if (rx_idle_en && $urandom_range(0, 9) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		offset_pair_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_offsets.size() == 0) begin
				report_mismatch("unexpected transfer", 32'h0, offset_x, offset_y);
			end else begin
				want = pending_offsets.pop_front();
				checked++;
				if (offset_x !== want.x)
					report_mismatch("offset_x", want.idx, offset_x, want.x);
				if (offset_y !== want.y)
					report_mismatch("offset_y", want.idx, offset_y, want.y);
			end
		end
	end

	task automatic test_directed();
		logic [31:0] corner[$];
		corner = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4, 32'hFFFFFFFF, 32'hFFFFFFFE,
			32'h80000000, 32'h7FFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'h00FFFFFF,
			32'hFF000000, 32'h00800000, 32'h01000000, 32'd59049, 32'd59048,
			32'd1162261467, 32'd3486784401, 32'd3486784400, 32'd3486784402, 32'h0000FFFF};
		foreach (corner[i])
			send_phase_index(corner[i]);
		wait_for_offsets();
	endtask

	// consecutive phases, as a renderer walks them
	task automatic test_sequential();
		logic [31:0] base;
		base = $urandom_range(0, 1) ? 32'h0 : $urandom;
		for (int i = 0; i < 200; i++)
			send_phase_index(base + i);
		wait_for_offsets();
	endtask

	task automatic test_random();
		logic [31:0]     idx;
		longint unsigned p3;
		for (int i = 0; i < 800; i++) begin
			case ($urandom_range(0, 4))
				0: idx = $urandom;
				1: idx = $urandom_range(0, 4095);
				2: idx = (32'h1 << $urandom_range(0, 31)) | (32'h1 << $urandom_range(0, 31));
				3: begin
					p3 = 1;
					repeat ($urandom_range(0, 20)) p3 = p3 * 3;
					idx = 32'(p3) + $urandom_range(0, 4) - 2;
				end
				default: idx = ~(32'h1 << $urandom_range(0, 31));
			endcase
			send_phase_index(idx);
		end
		wait_for_offsets();
	endtask

	task automatic test_backpressure();
		int stalls_before;
		stalls_before = input_stalls;
		tx_idle_en = 1'b0;
		hold_len = 200;
		hold_request = 1'b1;
		for (int i = 0; i < 150; i++)
			send_phase_index($urandom);
		wait_for_offsets();
		if (input_stalls == stalls_before)
			report_mismatch("no input stall under long hold", 32'h0, '0, '0);
		tx_idle_en = 1'b1;
	endtask

	task automatic test_streaming();
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		for (int i = 0; i < 100; i++)
			send_phase_index($urandom);
		wait_for_offsets();
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		phase_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_sequential();
		test_random();
		test_backpressure();
		test_streaming();
		repeat (60) @(posedge clk);
		$display("Sent %0d phase indices, checked %0d offset pairs (corners, runs, random).",
			sent, checked);
		$display("Saw %0d input stall cycles and %0d long output hold(s).", input_stalls,
			long_holds);
		if (errors == 0 && pending_offsets.size() == 0)
			$display("** halton_jitter_offset: PASSED **");
		else
			$display("** halton_jitter_offset: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d offset pairs outstanding", pending_offsets.size());
		$display("** halton_jitter_offset: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/hjo_pkg.sv
hw/rtl/hjo_digit_cell.sv
hw/rtl/hjo_div_cell.sv
hw/rtl/halton_jitter_offset.sv
hw/rtl/hjo_checker.sv
test/tb.sv
